// ----- rtl/grid_bfs_with_obstacle_removal_defines.svh -----
// Assertion macros for the grid search block.
`ifndef GRID_BFS_WITH_OBSTACLE_REMOVAL_DEFINES_SVH
`define GRID_BFS_WITH_OBSTACLE_REMOVAL_DEFINES_SVH
`ifndef SYNTH
`define GBFS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbfs check failed");
`define GBFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbfs check failed");
`else
`define GBFS_ASSERT_SAME(label, clk, rst, ante, cons)
`define GBFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/gbfs_pkg.sv -----
// Shared types and constants of the grid search block.
package gbfs_pkg;
  localparam int DEF_MAX_ROWS = 16;
  localparam int DEF_MAX_COLS = 16;
  localparam int DEF_MAX_REMOVALS = 31;
  localparam int STEP_W = 13;
  localparam int CFG_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOVALS = 2'd2;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] removals;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic [STEP_W-1:0] steps;
  } res_t;
endpackage

// ----- rtl/gbfs_ram.sv -----
// Synchronous one-write one-read memory with registered read data.
module gbfs_ram #(
  parameter int WIDTH = 1,
  parameter int AW = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/gbfs_engine.sv -----
// Search sequencer: cell map, visited map and frontier queue in memories.
module gbfs_engine #(
  parameter int MAX_ROWS = gbfs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gbfs_pkg::DEF_MAX_COLS,
  parameter int MAX_REMOVALS = gbfs_pkg::DEF_MAX_REMOVALS
) (
  input  logic           clk,
  input  logic           rst,
  input  gbfs_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           opcode,
  input  logic [3:0]     cell_row,
  input  logic [3:0]     cell_col,
  input  logic           cell_blocked,
  input  logic           out_free,
  output logic           res_valid,
  output gbfs_pkg::res_t res
);
  import gbfs_pkg::*;

  localparam int LEVELS = MAX_REMOVALS + 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int QW = RW + CW + LW;
  localparam int CNT_W = QW + 1;
  localparam int NW = 8;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLEAR = 8'b0000_0010,
    S_POP   = 8'b0000_0100,
    S_QWAIT = 8'b0000_1000,
    S_NBR   = 8'b0001_0000,
    S_CELL  = 8'b0010_0000,
    S_VIS   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] clr_cnt, head, tail, lvl_end;
  logic [STEP_W-1:0] level;
  logic [NW-1:0] rows_c, cols_c;
  logic [LW-1:0] budget;
  logic [RW-1:0] cur_r, nb_r;
  logic [CW-1:0] cur_c, nb_c;
  logic [LW-1:0] cur_l, nb_l;
  logic [1:0] dir;

  logic [NW-1:0] rows_cl, cols_cl, budget_cl;
  logic [NW-1:0] nr, nc;
  logic nb_ok, goal;
  logic [LW-1:0] nleft;

  logic cm_we, cm_rd;
  logic [RW+CW-1:0] cm_waddr, cm_raddr;
  logic vm_we, vm_wdata, vm_rd;
  logic [QW-1:0] vm_waddr, vm_raddr;
  logic q_we;
  logic [QW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

  assign rows_cl = (cfg.rows == '0) ? NW'(1) :
                   (NW'(cfg.rows) > NW'(MAX_ROWS)) ? NW'(MAX_ROWS) : NW'(cfg.rows);
  assign cols_cl = (cfg.cols == '0) ? NW'(1) :
                   (NW'(cfg.cols) > NW'(MAX_COLS)) ? NW'(MAX_COLS) : NW'(cfg.cols);
  assign budget_cl = (NW'(cfg.removals) > NW'(MAX_REMOVALS)) ? NW'(MAX_REMOVALS)
                                                            : NW'(cfg.removals);

  always_comb begin
    nr = NW'(cur_r);
    nc = NW'(cur_c);
    nb_ok = 1'b0;
    case (dir)
      2'd0: begin
        nr = NW'(cur_r) - NW'(1);
        nb_ok = (cur_r != '0);
      end
      2'd1: begin
        nc = NW'(cur_c) + NW'(1);
        nb_ok = (nc < cols_c);
      end
      2'd2: begin
        nr = NW'(cur_r) + NW'(1);
        nb_ok = (nr < rows_c);
      end
      default: begin
        nc = NW'(cur_c) - NW'(1);
        nb_ok = (cur_c != '0);
      end
    endcase
  end

  assign nleft = cm_rd ? cur_l - LW'(1) : cur_l;
  assign goal = (NW'(nb_r) == rows_c - NW'(1)) && (NW'(nb_c) == cols_c - NW'(1));

  assign in_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE) && out_free;

  always_comb begin
    cm_we = in_valid && in_ready && (opcode == OP_LOAD) &&
            (32'(cell_row) < MAX_ROWS) && (32'(cell_col) < MAX_COLS);
    cm_waddr = {RW'(cell_row), CW'(cell_col)};
    cm_raddr = {nr[RW-1:0], nc[CW-1:0]};
    vm_we = 1'b0;
    vm_wdata = 1'b0;
    vm_waddr = clr_cnt[QW-1:0];
    vm_raddr = {nb_r, nb_c, nleft};
    q_we = 1'b0;
    q_waddr = tail[QW-1:0];
    q_wdata = {nb_r, nb_c, nb_l};
    q_raddr = head[QW-1:0];
    if (state == S_CLEAR) begin
      vm_we = 1'b1;
      if (clr_cnt == CNT_W'(2**QW)) begin
        vm_wdata = 1'b1;
        vm_waddr = {RW'(0), CW'(0), budget};
        q_we = 1'b1;
        q_waddr = '0;
        q_wdata = {RW'(0), CW'(0), budget};
      end
    end else if ((state == S_VIS) && !vm_rd && !goal) begin
      vm_we = 1'b1;
      vm_wdata = 1'b1;
      vm_waddr = {nb_r, nb_c, nb_l};
      q_we = 1'b1;
    end
  end

  gbfs_ram #(.WIDTH(1), .AW(RW + CW)) u_cell_map (
    .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cell_blocked),
    .raddr(cm_raddr), .rdata(cm_rd)
  );

  gbfs_ram #(.WIDTH(1), .AW(QW)) u_visit_map (
    .clk(clk), .we(vm_we), .waddr(vm_waddr), .wdata(vm_wdata),
    .raddr(vm_raddr), .rdata(vm_rd)
  );

  gbfs_ram #(.WIDTH(QW), .AW(QW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      clr_cnt <= '0;
      head <= '0;
      tail <= '0;
      lvl_end <= '0;
      level <= '0;
      dir <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && (opcode == OP_START)) begin
            rows_c <= rows_cl;
            cols_c <= cols_cl;
            budget <= budget_cl[LW-1:0];
            if (budget_cl + NW'(3) > rows_cl + cols_cl) begin
              res.found <= 1'b1;
              res.steps <= STEP_W'(rows_cl + cols_cl - NW'(2));
              state <= S_DONE;
            end else begin
              clr_cnt <= '0;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (clr_cnt == CNT_W'(2**QW)) begin
            head <= '0;
            tail <= CNT_W'(1);
            lvl_end <= CNT_W'(1);
            level <= '0;
            state <= S_POP;
          end else begin
            clr_cnt <= clr_cnt + CNT_W'(1);
          end
        end
        S_POP: begin
          if (head == lvl_end) begin
            if (head == tail) begin
              res.found <= 1'b0;
              res.steps <= '0;
              state <= S_DONE;
            end else begin
              level <= level + STEP_W'(1);
              lvl_end <= tail;
            end
          end else begin
            head <= head + CNT_W'(1);
            state <= S_QWAIT;
          end
        end
        S_QWAIT: begin
          {cur_r, cur_c, cur_l} <= q_rdata;
          dir <= '0;
          state <= S_NBR;
        end
        S_NBR: begin
          if (nb_ok) begin
            nb_r <= nr[RW-1:0];
            nb_c <= nc[CW-1:0];
            state <= S_CELL;
          end else begin
            dir <= dir + 2'd1;
            state <= (dir == 2'd3) ? S_POP : S_NBR;
          end
        end
        S_CELL: begin
          if (cm_rd && (cur_l == '0)) begin
            dir <= dir + 2'd1;
            state <= (dir == 2'd3) ? S_POP : S_NBR;
          end else begin
            nb_l <= nleft;
            state <= S_VIS;
          end
        end
        S_VIS: begin
          if (!vm_rd && goal) begin
            res.found <= 1'b1;
            res.steps <= level + STEP_W'(1);
            state <= S_DONE;
          end else begin
            if (!vm_rd) begin
              tail <= tail + CNT_W'(1);
            end
            dir <= dir + 2'd1;
            state <= (dir == 2'd3) ? S_POP : S_NBR;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/grid_bfs_with_obstacle_removal.sv -----
// Top level of the grid shortest path search with obstacle removals.
// Usage: a load beat (s_tuser = 0) writes one grid cell and
// returns nothing. A start beat (s_tuser = 1) runs a breadth-first search
// from the top-left to the bottom-right cell and returns one beat on m_*:
// m_tuser is the found flag, m_tdata the step count (zero if not found).
// Configuration writes go over cfg_valid/cfg_index/cfg_data, always ready,
// and are made by the user while the block is idle; no logic checks this.
// Flow of a start beat: when the budget shortcut applies, the result goes
// straight to the output register. Otherwise the block first clears the
// visited map over all 2^(row bits + col bits + budget bits) addresses
// and seeds the queue with the start cell; then it dequeues each state and
// checks its four neighbours, skipping those off the grid or blocked with
// no removal left, using the registered reads of the cell, visited and
// queue memories; the result then passes through the output register.
// One item is worked on at a time; s_tready is low during a search.
// Reset clears the sequencer and output valid and sets the registers to
// 16 rows, 16 columns, 0 removals; the cell map holds no reset value.
// When the receiver stalls, the result waits in the output register and
// the block still takes load beats; a finished search holds until the
// output register frees.
module grid_bfs_with_obstacle_removal #(
  parameter int MAX_ROWS = gbfs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gbfs_pkg::DEF_MAX_COLS,
  parameter int MAX_REMOVALS = gbfs_pkg::DEF_MAX_REMOVALS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,  // cell_row, cell_col, cell_blocked, 0
  input  logic                           s_tuser,  // opcode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,  // path_steps, 0
  output logic                           m_tuser,  // path_found
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbfs_pkg::CFG_W-1:0]     cfg_data
);
  import gbfs_pkg::*;

  `include "grid_bfs_with_obstacle_removal_defines.svh"

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic out_free;
  logic [STEP_W-1:0] steps;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows <= CFG_W'(16);
      cfg.cols <= CFG_W'(16);
      cfg.removals <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROWS:     cfg.rows <= cfg_data;
        CFG_COLS:     cfg.cols <= cfg_data;
        CFG_REMOVALS: cfg.removals <= cfg_data;
        default:      ;
      endcase
    end
  end

  gbfs_engine #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_REMOVALS(MAX_REMOVALS)
  ) u_engine (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .opcode(s_tuser), .cell_row(s_tdata[3:0]), .cell_col(s_tdata[7:4]),
    .cell_blocked(s_tdata[8]),
    .out_free(out_free), .res_valid(res_valid), .res(res)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tuser <= res.found;
      steps <= res.steps;
    end
  end

  assign m_tdata = {{(16 - STEP_W){1'b0}}, steps};

  `GBFS_ASSERT_SAME(a_res_slot_free, clk, rst, res_valid, !m_tvalid || m_tready)
  `GBFS_ASSERT_NEXT(a_start_busy, clk, rst, s_tvalid && s_tready && s_tuser == OP_START, !s_tready)
  `GBFS_ASSERT_SAME(a_miss_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)
endmodule
